### hw/rtl/usbrx_pkg.sv
// ----------------------------------------------------------------------------
// USB receive deframer package
// Shared widths, limits and the result word type of the bulk receive deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package usbrx_pkg;

   // Largest bulk transfer that the deframer tracks; longer lengths saturate.
   localparam int MaxTransfer = 2048;

   // Width of the bytes-left counters, wide enough to hold MaxTransfer itself.
   localparam int LeftWidth = $clog2(MaxTransfer + 1);

   // Fixed field widths of the channels.
   localparam int ByteWidth = 8;
   localparam int LenWidth  = 12;

   // Each frame header is four bytes; the upper half is the inverted length.
   localparam int          HeaderBytes = 4;
   localparam logic [15:0] CheckMask   = 16'hFFFF;

   // One word on the result channel.
   typedef struct packed {
      logic [ByteWidth-1:0] frame_byte;
      logic                 frame_last;
      logic                 frame_empty;
   } result_type;

endpackage : usbrx_pkg

`default_nettype wire

### hw/rtl/usbrx_deframe_core.sv
// ----------------------------------------------------------------------------
// USB receive deframer core
// Holds the framing state and works out, for one buffered byte, the next state
// and whether a frame word comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module usbrx_deframe_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire logic [usbrx_pkg::ByteWidth-1:0]   rx_byte,
   input  wire logic                              start_of_transfer,
   input  wire logic [usbrx_pkg::LenWidth-1:0]    transfer_length,
   output logic                                   has_result,
   output usbrx_pkg::result_type                  result
);

   localparam logic [1:0] PhDiscard = 2'd0;
   localparam logic [1:0] PhHeader  = 2'd1;
   localparam logic [1:0] PhPayload = 2'd2;

   localparam int Lw = usbrx_pkg::LeftWidth;

   // Framing state.
   logic [1:0]    phase_ff, phase_in;
   logic [23:0]   shift_ff, shift_in;
   logic [1:0]    count_ff, count_in;
   logic [Lw-1:0] left_ff, left_in;
   logic [Lw-1:0] frame_ff, frame_in;

   // State as seen after a possible start mark.
   logic [1:0]    ph;
   logic [23:0]   hs;
   logic [1:0]    hc;
   logic [Lw-1:0] tl;
   logic [Lw-1:0] fl;

   logic [Lw-1:0] len_sat;
   logic [Lw-1:0] tl_dec;
   logic [Lw-1:0] fl_dec;
   logic [23:0]   byte_placed;
   logic [31:0]   header_word;
   logic [15:0]   hdr_len;
   logic [15:0]   hdr_chk;
   logic          hdr_bad;

   // Zero length counts as one byte; longer transfers saturate at the limit.
   always_comb begin
      priority if (transfer_length == '0) begin
         len_sat = Lw'(1);
      end else if (int'(transfer_length) > usbrx_pkg::MaxTransfer) begin
         len_sat = Lw'(usbrx_pkg::MaxTransfer);
      end else begin
         len_sat = Lw'(transfer_length);
      end
   end

   // A start mark restarts the transfer before the byte is looked at.
   always_comb begin
      if (start_of_transfer) begin
         ph = PhHeader;
         tl = len_sat;
         hs = '0;
         hc = '0;
         fl = '0;
      end else begin
         ph = phase_ff;
         tl = left_ff;
         hs = shift_ff;
         hc = count_ff;
         fl = frame_ff;
      end
   end

   // Place the incoming byte at its header position; the fourth byte is used directly.
   always_comb begin
      unique case (hc)
         2'd0:    byte_placed = {16'd0, rx_byte};
         2'd1:    byte_placed = {8'd0, rx_byte, 8'd0};
         2'd2:    byte_placed = {rx_byte, 16'd0};
         default: byte_placed = '0;
      endcase
   end

   // Header check: length must match its inverse and fit in what is left.
   assign tl_dec      = tl - Lw'(1);
   assign header_word = {rx_byte, hs};
   assign hdr_len     = header_word[15:0];
   assign hdr_chk     = header_word[31:16] ^ usbrx_pkg::CheckMask;
   assign hdr_bad     = (hdr_len != hdr_chk) || (32'(hdr_len) > 32'(tl_dec));
   assign fl_dec      = (fl != '0) ? (fl - Lw'(1)) : fl;

   // Next state and result for the buffered byte.
   always_comb begin
      phase_in           = ph;
      left_in            = tl;
      shift_in           = hs;
      count_in           = hc;
      frame_in           = fl;
      has_result         = 1'b0;
      result.frame_byte  = '0;
      result.frame_last  = 1'b0;
      result.frame_empty = 1'b0;
      if ((ph == PhHeader) || (ph == PhPayload)) begin
         if (tl == '0) begin
            phase_in = PhDiscard;
         end else begin
            if (ph == PhHeader) begin
               if ((hc == 2'd0) && (tl < Lw'(usbrx_pkg::HeaderBytes))) begin
                  phase_in = PhDiscard;
               end else if (hc != 2'd3) begin
                  shift_in = hs | byte_placed;
                  count_in = hc + 2'd1;
               end else begin
                  shift_in = '0;
                  count_in = '0;
                  if (hdr_bad) begin
                     phase_in = PhDiscard;
                  end else if (hdr_len == '0) begin
                     // Empty frame: one marker word.
                     has_result         = 1'b1;
                     result.frame_last  = 1'b1;
                     result.frame_empty = 1'b1;
                  end else begin
                     frame_in = hdr_len[Lw-1:0];
                     phase_in = PhPayload;
                  end
               end
            end else begin
               frame_in          = fl_dec;
               has_result        = 1'b1;
               result.frame_byte = rx_byte;
               result.frame_last = (fl_dec == '0);
               if (fl_dec == '0) begin
                  phase_in = PhHeader;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            // Count the byte off the transfer; at its end go back to idle.
            left_in = tl_dec;
            if (tl_dec == '0) begin
               phase_in = PhDiscard;
               count_in = '0;
               shift_in = '0;
               frame_in = '0;
            end
         end
      end
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhDiscard;
         shift_ff <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         frame_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         frame_ff <= frame_in;
      end
   end

endmodule : usbrx_deframe_core

`default_nettype wire

### hw/rtl/usb_ether_rx_deframer_unit.sv
// ----------------------------------------------------------------------------
// USB Ethernet receive deframer
// Splits a USB bulk transfer, one byte per word, into Ethernet frame words.
//
//   channel   direction   word contents
//   req_      in          rx_byte, start_of_transfer, transfer_length
//   rsp_      out         frame_byte, frame_last, frame_empty
//
// A byte waits in the input register while the core updates the
// framing state; its frame word, if any, is loaded into the output register
// as the byte leaves. One byte per cycle is sustained; the only limit is the
// output register draining. Reset is synchronous and clears both registers'
// valid flags and the framing state. A stalled result holds the output and,
// when the buffered byte has a result to deliver, holds the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_ether_rx_deframer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [usbrx_pkg::ByteWidth-1:0]   req_rx_byte,
   input  wire logic                              req_start_of_transfer,
   input  wire logic [usbrx_pkg::LenWidth-1:0]    req_transfer_length,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [usbrx_pkg::ByteWidth-1:0]        rsp_frame_byte,
   output logic                                   rsp_frame_last,
   output logic                                   rsp_frame_empty
);

   // Input register.
   logic                              stage_valid_ff, stage_valid_in;
   logic [usbrx_pkg::ByteWidth-1:0]   stage_byte_ff;
   logic                              stage_sot_ff;
   logic [usbrx_pkg::LenWidth-1:0]    stage_len_ff;

   // Output register.
   logic                              out_valid_ff, out_valid_in;
   usbrx_pkg::result_type             out_word_ff;

   logic                              has_result;
   usbrx_pkg::result_type             result;
   logic                              out_free;
   logic                              advance;
   logic                              load_out;

   usbrx_deframe_core u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .rx_byte           (stage_byte_ff),
      .start_of_transfer (stage_sot_ff),
      .transfer_length   (stage_len_ff),
      .has_result        (has_result),
      .result            (result)
   );

   // The buffered byte moves on unless its word cannot enter the output.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && (!has_result || out_free);
   assign load_out  = advance && has_result;
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff <= req_rx_byte;
         stage_sot_ff  <= req_start_of_transfer;
         stage_len_ff  <= req_transfer_length;
      end
      if (load_out) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_byte  = out_word_ff.frame_byte;
   assign rsp_frame_last  = out_word_ff.frame_last;
   assign rsp_frame_empty = out_word_ff.frame_empty;

`ifndef SYNTHESIS
   // An empty-frame marker always closes its frame and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_empty) |-> (rsp_frame_last && (rsp_frame_byte == '0)))
      else $error("empty frame marker without last mark or with nonzero byte");

   // The input side only stalls when a buffered byte waits behind a full output.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked output");

   // Nothing is shown on the result channel right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid directly after reset");

   // A held result is not overwritten while the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !load_out)
      else $error("output register loaded while stalled");
`endif

endmodule : usb_ether_rx_deframer_unit

`default_nettype wire
